// ===== hdl/rahb_pkg.sv =====
// Shared types and constants of the recent allocation hash table.
package rahb_pkg;

   localparam int ADDR_W     = 64;
   localparam int FUNC_W     = 2;
   localparam int HASH_SHIFT = 8;
   localparam int DIGIT_W    = 8;
   localparam int DIGITS     = ADDR_W / DIGIT_W;

   typedef enum logic [FUNC_W-1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [ADDR_W-1:0]   address;
   } item_type;

endpackage

// ===== hdl/recent_alloc_hash_buckets.sv =====
// Top level of the recent allocation hash table.
//
//  channel | ports                          | direction
//  --------+--------------------------------+----------
//  req     | req_valid req_stall req_func   | in
//          | req_address                    |
//  rsp     | rsp_valid rsp_stall rsp_found  | out
//
// Insert and lookup pass the bucket engine in ST_IDLE, which reads the bucket row, and in
// ST_EXEC, which updates and writes it back; only then does the engine take the next word.
// Other bucket counts first reduce the hash in the front end, one hash byte reduced per cycle.
// A clear sweeps BUCKETS rows, one per cycle; after reset the same sweep runs while
// req_stall stays high.
// A stalled response holds in the output register while the front end keeps taking
// up to four more requests.
module recent_alloc_hash_buckets #(
   parameter int BUCKETS = 256,
   parameter int WAYS    = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [rahb_pkg::FUNC_W-1:0]  req_func,
   input  logic [rahb_pkg::ADDR_W-1:0]  req_address,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_found
);

   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int QW = BW + $bits(rahb_pkg::item_type);

   logic                  push;
   logic                  q_full;
   logic                  q_valid;
   logic                  pop;
   logic                  init_busy;
   rahb_pkg::item_type    fr_item;
   logic [BW-1:0]         fr_bucket;
   logic [QW-1:0]         q_dout;
   rahb_pkg::item_type    q_item;
   logic [BW-1:0]         q_bucket;

   rahb_front #(
      .BUCKETS(BUCKETS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .hold       (init_busy),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_func   (req_func),
      .req_address(req_address),
      .push       (push),
      .q_full     (q_full),
      .out_item   (fr_item),
      .out_bucket (fr_bucket)
   );

   rahb_queue #(
      .DW(QW)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push (push),
      .din  ({fr_bucket, fr_item}),
      .full (q_full),
      .pop  (pop),
      .valid(q_valid),
      .dout (q_dout)
   );

   assign q_bucket = q_dout[QW-1 -: BW];
   assign q_item   = q_dout[QW-BW-1:0];

   rahb_back #(
      .BUCKETS(BUCKETS),
      .WAYS   (WAYS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .pop      (pop),
      .q_item   (q_item),
      .q_bucket (q_bucket),
      .init_busy(init_busy),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_found(rsp_found)
   );

endmodule

// ===== hdl/rahb_front.sv =====
// Front end: takes request words, decodes the function and reduces the address hash to a bucket.
module rahb_front #(
   parameter int BUCKETS = 256,
   localparam int BW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         hold,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [rahb_pkg::FUNC_W-1:0]  req_func,
   input  logic [rahb_pkg::ADDR_W-1:0]  req_address,
   output logic                         push,
   input  logic                         q_full,
   output rahb_pkg::item_type           out_item,
   output logic [BW-1:0]                out_bucket
);

   localparam bit POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
   localparam int SW   = $clog2(rahb_pkg::DIGITS);

   logic                         accept;
   logic [rahb_pkg::ADDR_W-1:0]  hash;
   logic                         fr_done;
   logic                         fr_valid_ff;
   logic                         fr_valid_in;
   rahb_pkg::item_type           fr_item_ff;
   logic [BW-1:0]                fr_bucket_ff;

   assign hash      = (req_address >> rahb_pkg::HASH_SHIFT) ^ req_address;
   assign push      = fr_valid_ff & fr_done & ~q_full;
   assign req_stall = hold | (fr_valid_ff & ~push);
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      fr_valid_in = fr_valid_ff;
      if (accept) begin
         fr_valid_in = 1'b1;
      end else if (push) begin
         fr_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_valid_ff <= 1'b0;
      end else begin
         fr_valid_ff <= fr_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fr_item_ff.op      <= rahb_pkg::op_type'(req_func);
         fr_item_ff.address <= req_address;
      end
   end

   generate
      if (POW2) begin : g_mask
         assign fr_done = 1'b1;

         always_ff @(posedge clock) begin
            if (accept) begin
               fr_bucket_ff <= (BUCKETS == 1) ? '0 : hash[BW-1:0];
            end
         end
      end else begin : g_reduce
         logic [rahb_pkg::ADDR_W-1:0]  fr_hash_ff;
         logic [SW-1:0]                fr_step_ff;
         logic                         fr_done_ff;
         logic [BW-1:0]                rem_in;

         // Fold one byte of the hash into the remainder, MSB first.
         always_comb begin
            logic [BW:0] w;
            rem_in = fr_bucket_ff;
            for (int k = rahb_pkg::DIGIT_W - 1; k >= 0; k--) begin
               w = {rem_in, fr_hash_ff[rahb_pkg::ADDR_W - rahb_pkg::DIGIT_W + k]};
               if (w >= (BW + 1)'(BUCKETS)) begin
                  w = w - (BW + 1)'(BUCKETS);
               end
               rem_in = w[BW-1:0];
            end
         end

         assign fr_done = fr_done_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               fr_done_ff <= 1'b0;
               fr_step_ff <= '0;
            end else if (accept) begin
               fr_done_ff <= 1'b0;
               fr_step_ff <= '0;
            end else if (fr_valid_ff && !fr_done_ff) begin
               fr_step_ff <= fr_step_ff + 1'b1;
               if (fr_step_ff == SW'(rahb_pkg::DIGITS - 1)) begin
                  fr_done_ff <= 1'b1;
               end
            end
         end

         always_ff @(posedge clock) begin
            if (accept) begin
               fr_hash_ff   <= hash;
               fr_bucket_ff <= '0;
            end else if (fr_valid_ff && !fr_done_ff) begin
               fr_hash_ff   <= fr_hash_ff << rahb_pkg::DIGIT_W;
               fr_bucket_ff <= rem_in;
            end
         end
      end
   endgenerate

   assign out_item   = fr_item_ff;
   assign out_bucket = fr_bucket_ff;

endmodule

// ===== hdl/rahb_queue.sv =====
// Two-entry queue between the front end and the bucket engine.
module rahb_queue #(
   parameter int DW = 8
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  logic [DW-1:0]  din,
   output logic           full,
   input  logic           pop,
   output logic           valid,
   output logic [DW-1:0]  dout
);

   logic [1:0][DW-1:0]  slot_ff;
   logic                wr_ptr_ff;
   logic                rd_ptr_ff;
   logic [1:0]          cnt_ff;
   logic [1:0]          cnt_in;

   assign full  = (cnt_ff == 2'd2);
   assign valid = (cnt_ff != 2'd0);
   assign dout  = slot_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// ===== hdl/rahb_back.sv =====
// Bucket engine: reads a bucket row, applies insert or lookup, writes it back, sweeps on clear.
module rahb_back #(
   parameter int BUCKETS = 256,
   parameter int WAYS    = 4,
   localparam int BW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   output logic                pop,
   input  rahb_pkg::item_type  q_item,
   input  logic [BW-1:0]       q_bucket,
   output logic                init_busy,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_found
);

   localparam int AW    = rahb_pkg::ADDR_W;
   localparam int PW    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int CW    = $clog2(WAYS + 1);
   localparam int ROW_W = WAYS * AW + PW + CW;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_EXEC  = 4'b0010,
      ST_RESP  = 4'b0100,
      ST_SWEEP = 4'b1000
   } state_type;

   logic [ROW_W-1:0]       row_mem [BUCKETS];
   logic [ROW_W-1:0]       rd_row_ff;

   state_type              state_ff, state_in;
   rahb_pkg::item_type     cur_item_ff, cur_item_in;
   logic [BW-1:0]          cur_bucket_ff, cur_bucket_in;
   logic [BW-1:0]          sweep_idx_ff, sweep_idx_in;
   logic                   sweep_rsp_ff, sweep_rsp_in;
   logic                   found_ff, found_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_found_ff, rsp_found_in;

   logic                   rd_en;
   logic                   mem_we;
   logic [BW-1:0]          mem_waddr;
   logic [ROW_W-1:0]       mem_wdata;
   logic [ROW_W-1:0]       new_row;
   logic                   hit;
   logic                   out_free;

   // Row update for insert and lookup.
   always_comb begin
      logic [WAYS-1:0][AW-1:0] ways;
      logic [WAYS-1:0][AW-1:0] new_ways;
      logic [PW-1:0]           ptr;
      logic [PW-1:0]           new_ptr;
      logic [CW-1:0]           cnt;
      logic [CW-1:0]           new_cnt;
      logic [PW-1:0]           midx;
      logic [PW-1:0]           zidx;
      logic                    full;
      ways = rd_row_ff[WAYS*AW-1:0];
      ptr  = rd_row_ff[WAYS*AW +: PW];
      cnt  = rd_row_ff[WAYS*AW+PW +: CW];
      full = (cnt == CW'(WAYS));
      hit  = 1'b0;
      midx = '0;
      zidx = '0;
      // First match wins; the victim falls back to the last empty filled way.
      for (int i = 0; i < WAYS; i++) begin
         if (CW'(i) < cnt && ways[i] == cur_item_ff.address && !hit) begin
            hit  = 1'b1;
            midx = PW'(i);
         end
         if (CW'(i) < cnt && ways[i] == '0) begin
            zidx = PW'(i);
         end
      end
      new_ways = ways;
      new_ptr  = ptr;
      new_cnt  = cnt;
      if (cur_item_ff.op == rahb_pkg::OP_INSERT) begin
         for (int i = 0; i < WAYS; i++) begin
            if (PW'(i) == ptr) begin
               new_ways[i] = cur_item_ff.address;
            end
         end
         new_ptr = (ptr == PW'(WAYS - 1)) ? '0 : ptr + 1'b1;
         if (!full) begin
            new_cnt = cnt + 1'b1;
         end
      end else begin
         for (int i = 0; i < WAYS; i++) begin
            if (hit && PW'(i) == midx) begin
               new_ways[i] = '0;
            end
         end
         if (full) begin
            new_ptr = hit ? midx : zidx;
         end
      end
      new_row = {new_cnt, new_ptr, new_ways};
   end

   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      state_in      = state_ff;
      pop           = 1'b0;
      rd_en         = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = cur_bucket_ff;
      mem_wdata     = new_row;
      cur_item_in   = cur_item_ff;
      cur_bucket_in = cur_bucket_ff;
      sweep_idx_in  = sweep_idx_ff;
      sweep_rsp_in  = sweep_rsp_ff;
      found_in      = found_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_found_in  = rsp_found_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               pop           = 1'b1;
               cur_item_in   = q_item;
               cur_bucket_in = q_bucket;
               case (q_item.op)
                  rahb_pkg::OP_INSERT, rahb_pkg::OP_LOOKUP: begin
                     rd_en    = 1'b1;
                     state_in = ST_EXEC;
                  end
                  rahb_pkg::OP_CLEAR: begin
                     sweep_idx_in = '0;
                     sweep_rsp_in = 1'b1;
                     state_in     = ST_SWEEP;
                  end
                  default: begin
                     found_in = 1'b0;
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_EXEC: begin
            mem_we = 1'b1;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = hit & (cur_item_ff.op == rahb_pkg::OP_LOOKUP);
               state_in     = ST_IDLE;
            end else begin
               found_in = hit & (cur_item_ff.op == rahb_pkg::OP_LOOKUP);
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            // Zero the whole row of one bucket per cycle: ways, pointer and count.
            mem_we    = 1'b1;
            mem_waddr = sweep_idx_ff;
            mem_wdata = '0;
            if (sweep_idx_ff == BW'(BUCKETS - 1)) begin
               if (sweep_rsp_ff) begin
                  found_in = 1'b0;
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               sweep_idx_in = sweep_idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_idx_ff <= '0;
         sweep_rsp_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_idx_ff <= sweep_idx_in;
         sweep_rsp_ff <= sweep_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_item_ff   <= cur_item_in;
      cur_bucket_ff <= cur_bucket_in;
      found_ff      <= found_in;
      rsp_found_ff  <= rsp_found_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         row_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_row_ff <= row_mem[q_bucket];
      end
   end

   assign init_busy = (state_ff == ST_SWEEP) & ~sweep_rsp_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;

endmodule

// ===== hdl/rahb_checker.sv =====
// Port-level checks of the recent allocation hash table and their binding.
module rahb_checker (
   input  logic  clock,
   input  logic  reset,
   input  logic  req_valid,
   input  logic  req_stall,
   input  logic  rsp_valid,
   input  logic  rsp_stall,
   input  logic  rsp_found
);

   logic        req_take;
   logic        rsp_take;
   logic [2:0]  open_ff;

   assign req_take = req_valid & ~req_stall;
   assign rsp_take = rsp_valid & ~rsp_stall;

   // Words accepted but not yet answered.
   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 3'd0;
      end else if (req_take && !rsp_take) begin
         open_ff <= open_ff + 3'd1;
      end else if (rsp_take && !req_take) begin
         open_ff <= open_ff - 3'd1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found))
      else $error("stalled response word dropped or changed");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> (open_ff != 3'd0) || req_take)
      else $error("response word without an accepted request");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      open_ff <= 3'd5)
      else $error("more words in flight than the design can hold");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_found_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_found))
      else $error("response word carries unknown found bit");

endmodule

bind recent_alloc_hash_buckets rahb_checker u_rahb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_found  (rsp_found)
);
